/* design/pcrp_pkg.sv */
// shared types and constants for the proxy connect request parser
package pcrp_pkg;

   localparam int unsigned SOCKS_VERSION   = 5;
   localparam int unsigned CMD_CONNECT     = 1;
   localparam int unsigned RSV_VALUE       = 0;
   localparam int unsigned ATYP_IPV4       = 1;
   localparam int unsigned ATYP_DOMAIN     = 3;
   localparam int unsigned ATYP_IPV6       = 4;
   localparam int unsigned LEN_IPV4        = 10;
   localparam int unsigned LEN_IPV6        = 22;
   localparam int unsigned DOMAIN_OVERHEAD = 7;
   localparam int unsigned HEADER_LEN      = 4;
   localparam int unsigned PORT_LEN        = 2;
   localparam int unsigned COUNT_W         = 9;
   localparam int unsigned COUNT_MAX       = 511;
   localparam int unsigned QUEUE_DEPTH     = 4;

   typedef enum logic [1:0] {
      KIND_ADDR   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ADDR_NONE   = 2'd0,
      ADDR_IPV4   = 2'd1,
      ADDR_DOMAIN = 2'd2,
      ADDR_IPV6   = 2'd3
   } addr_kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      logic [15:0] port_number;
      logic        is_domain;
      logic [7:0]  addr_length;
   } result_type;

endpackage

/* design/pcrp_front.sv */
// front end: takes request bytes, tracks message state and classifies each byte
module pcrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_message,
   output logic                 push,
   output pcrp_pkg::result_type push_data
);
   import pcrp_pkg::*;

   localparam logic [COUNT_W-1:0] P_VER     = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] P_CMD     = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] P_RSV     = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] P_ATYP    = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] P_DLEN    = COUNT_W'(HEADER_LEN);
   localparam logic [COUNT_W-1:0] V4_PORT   = COUNT_W'(LEN_IPV4 - PORT_LEN);
   localparam logic [COUNT_W-1:0] V4_END    = COUNT_W'(LEN_IPV4);
   localparam logic [COUNT_W-1:0] V6_PORT   = COUNT_W'(LEN_IPV6 - PORT_LEN);
   localparam logic [COUNT_W-1:0] V6_END    = COUNT_W'(LEN_IPV6);
   localparam logic [COUNT_W-1:0] DOM_START = COUNT_W'(HEADER_LEN + 1);
   localparam logic [COUNT_W-1:0] DOM_OVH   = COUNT_W'(DOMAIN_OVERHEAD);
   localparam logic [COUNT_W-1:0] CNT_MAX   = COUNT_W'(COUNT_MAX);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               bad_ff, bad_in;
   addr_kind_type      kind_ff, kind_in;
   logic [7:0]         dlen_ff, dlen_in;
   logic [15:0]        port_ff, port_in;

   logic               is_addr;
   logic               is_port;
   logic [7:0]         idx;
   logic [COUNT_W-1:0] dlen_ext;
   logic [COUNT_W-1:0] need;
   logic [7:0]         alen;
   logic               ok;

   always_comb begin
      bad_in   = bad_ff;
      kind_in  = kind_ff;
      dlen_in  = dlen_ff;
      is_addr  = 1'b0;
      is_port  = 1'b0;
      idx      = 8'd0;
      dlen_ext = {1'b0, dlen_ff};

      if (count_ff == P_VER) begin
         if (in_byte != 8'(SOCKS_VERSION)) bad_in = 1'b1;
      end else if (count_ff == P_CMD) begin
         if (in_byte != 8'(CMD_CONNECT)) bad_in = 1'b1;
      end else if (count_ff == P_RSV) begin
         if (in_byte != 8'(RSV_VALUE)) bad_in = 1'b1;
      end else if (count_ff == P_ATYP) begin
         if (in_byte == 8'(ATYP_IPV4)) begin
            kind_in = ADDR_IPV4;
         end else if (in_byte == 8'(ATYP_DOMAIN)) begin
            kind_in = ADDR_DOMAIN;
         end else if (in_byte == 8'(ATYP_IPV6)) begin
            kind_in = ADDR_IPV6;
         end else begin
            kind_in = ADDR_NONE;
            bad_in  = 1'b1;
         end
      end else begin
         unique case (kind_ff)
            ADDR_IPV4: begin
               if (count_ff < V4_PORT) begin
                  is_addr = 1'b1;
                  idx     = 8'(count_ff - P_DLEN);
               end else if (count_ff < V4_END) begin
                  is_port = 1'b1;
               end
            end
            ADDR_IPV6: begin
               if (count_ff < V6_PORT) begin
                  is_addr = 1'b1;
                  idx     = 8'(count_ff - P_DLEN);
               end else if (count_ff < V6_END) begin
                  is_port = 1'b1;
               end
            end
            ADDR_DOMAIN: begin
               if (count_ff == P_DLEN) begin
                  dlen_in = in_byte;
               end else if (count_ff < DOM_START + dlen_ext) begin
                  is_addr = 1'b1;
                  idx     = 8'(count_ff - DOM_START);
               end else if (count_ff < DOM_OVH + dlen_ext) begin
                  is_port = 1'b1;
               end
            end
            default: ;
         endcase
      end

      port_in  = is_port ? {port_ff[7:0], in_byte} : port_ff;
      count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

      need = '0;
      alen = 8'd0;
      unique case (kind_in)
         ADDR_IPV4: begin
            need = V4_END;
            alen = 8'(HEADER_LEN);
         end
         ADDR_IPV6: begin
            need = V6_END;
            alen = 8'(LEN_IPV6 - LEN_IPV4 + HEADER_LEN);
         end
         ADDR_DOMAIN: begin
            need = {1'b0, dlen_in} + DOM_OVH;
            alen = dlen_in;
         end
         default: ;
      endcase
      ok = !bad_in && (kind_in != ADDR_NONE) && (count_in == need);

      push = accept && (end_of_message || is_addr);
      if (end_of_message) begin
         push_data.kind        = ok ? KIND_ACCEPT : KIND_REJECT;
         push_data.addr_byte   = 8'd0;
         push_data.addr_index  = 8'd0;
         push_data.port_number = ok ? port_in : 16'd0;
         push_data.is_domain   = ok && (kind_in == ADDR_DOMAIN);
         push_data.addr_length = ok ? alen : 8'd0;
      end else begin
         push_data.kind        = KIND_ADDR;
         push_data.addr_byte   = in_byte;
         push_data.addr_index  = idx;
         push_data.port_number = 16'd0;
         push_data.is_domain   = 1'b0;
         push_data.addr_length = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_message)) begin
         count_ff <= '0;
         bad_ff   <= 1'b0;
         kind_ff  <= ADDR_NONE;
         dlen_ff  <= 8'd0;
         port_ff  <= 16'd0;
      end else if (accept) begin
         count_ff <= count_in;
         bad_ff   <= bad_in;
         kind_ff  <= kind_in;
         dlen_ff  <= dlen_in;
         port_ff  <= port_in;
      end
   end

endmodule

/* design/pcrp_queue.sv */
// short result queue between the front end and the output stage
module pcrp_queue #(
   parameter int unsigned Depth = pcrp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcrp_pkg::result_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 q_valid,
   output pcrp_pkg::result_type q_data
);
   import pcrp_pkg::*;

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   result_type      mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign q_valid = (count_ff != '0);
   assign q_data  = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* design/pcrp_back.sv */
// output stage: registers results from the queue onto the response channel
module pcrp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pcrp_pkg::result_type q_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_addr_byte,
   output logic [7:0]           rsp_addr_index,
   output logic [15:0]          rsp_port_number,
   output logic                 rsp_is_domain,
   output logic [7:0]           rsp_addr_length
);
   import pcrp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign pop = q_valid && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= q_data;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = data_ff.kind;
   assign rsp_addr_byte   = data_ff.addr_byte;
   assign rsp_addr_index  = data_ff.addr_index;
   assign rsp_port_number = data_ff.port_number;
   assign rsp_is_domain   = data_ff.is_domain;
   assign rsp_addr_length = data_ff.addr_length;

endmodule

/* design/proxy_connect_request_parser.sv */
// top level of the proxy connect request parser
//
// request channel: one byte of a connect request per request, with
// req_end_of_message set on the final byte. a byte is taken at a clock
// edge with req_valid high and req_stall low.
// response channel: one response per address byte before the final byte
// (rsp_kind address, with value and index) and one verdict per message
// (accept or reject, with port, domain flag and address length on accept).
// path: a response passes through the queue and then the output register
// on its way to the rsp_ ports. throughput: one byte per cycle while req_stall
// is low; the front end updates its per-byte state as each byte is taken, and
// the queue lets it run ahead of the output register.
// stall: while rsp_stall is high the output register holds and the queue
// fills; req_stall rises once the queue (QueueDepth entries) is full.
// reset: synchronous, clears the message state, the queue and the output
// valid; the block can take bytes as soon as reset is low.
module proxy_connect_request_parser #(
   parameter int unsigned QueueDepth = pcrp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_addr_byte,
   output logic [7:0]  rsp_addr_index,
   output logic [15:0] rsp_port_number,
   output logic        rsp_is_domain,
   output logic [7:0]  rsp_addr_length
);
   import pcrp_pkg::*;

   logic       accept;
   logic       push;
   result_type push_data;
   logic       full;
   logic       pop;
   logic       q_valid;
   result_type q_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   pcrp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .end_of_message (req_end_of_message),
      .push           (push),
      .push_data      (push_data)
   );

   pcrp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   pcrp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_addr_byte   (rsp_addr_byte),
      .rsp_addr_index  (rsp_addr_index),
      .rsp_port_number (rsp_port_number),
      .rsp_is_domain   (rsp_is_domain),
      .rsp_addr_length (rsp_addr_length)
   );

endmodule

/* tb/testbench.sv */
// testbench for the proxy connect request parser: scoreboard, stimulus and checks
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pcrp_pkg::*;

   localparam int unsigned QuietLimit = 1000;
   localparam int unsigned HoldOffCycles = 80;
   localparam int unsigned PhaseItems = 240;

   class parser_scoreboard;
      logic [8:0]    seen_count;
      bit            header_bad;
      addr_kind_type atyp_kind;
      logic [7:0]    name_length;
      logic [15:0]   port_bytes;
      result_type    awaited[$];
      int unsigned   failures;

      function new();
         clear();
         failures = 0;
      endfunction

      function void clear();
         seen_count  = '0;
         header_bad  = 1'b0;
         atyp_kind   = ADDR_NONE;
         name_length = '0;
         port_bytes  = '0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void note_request(logic [7:0] value, logic last);
         int unsigned pos;
         int unsigned need;
         bit          is_addr;
         bit          is_port;
         bit          ok;
         logic [7:0]  idx;
         logic [7:0]  alen;
         result_type  want;
         pos     = seen_count;
         is_addr = 1'b0;
         is_port = 1'b0;
         idx     = '0;
         need    = 0;
         alen    = '0;
         want    = '0;
         if (pos == 0) begin
            if (value != SOCKS_VERSION) header_bad = 1'b1;
         end else if (pos == 1) begin
            if (value != CMD_CONNECT) header_bad = 1'b1;
         end else if (pos == 2) begin
            if (value != RSV_VALUE) header_bad = 1'b1;
         end else if (pos == HEADER_LEN - 1) begin
            if (value == ATYP_IPV4) atyp_kind = ADDR_IPV4;
            else if (value == ATYP_DOMAIN) atyp_kind = ADDR_DOMAIN;
            else if (value == ATYP_IPV6) atyp_kind = ADDR_IPV6;
            else begin
               atyp_kind  = ADDR_NONE;
               header_bad = 1'b1;
            end
         end else if (atyp_kind == ADDR_IPV4) begin
            if (pos < LEN_IPV4 - PORT_LEN) begin
               is_addr = 1'b1;
               idx     = 8'(pos - HEADER_LEN);
            end else if (pos < LEN_IPV4) is_port = 1'b1;
         end else if (atyp_kind == ADDR_IPV6) begin
            if (pos < LEN_IPV6 - PORT_LEN) begin
               is_addr = 1'b1;
               idx     = 8'(pos - HEADER_LEN);
            end else if (pos < LEN_IPV6) is_port = 1'b1;
         end else if (atyp_kind == ADDR_DOMAIN) begin
            if (pos == HEADER_LEN) name_length = value;
            else if (pos < HEADER_LEN + 1 + name_length) begin
               is_addr = 1'b1;
               idx     = 8'(pos - HEADER_LEN - 1);
            end else if (pos < DOMAIN_OVERHEAD + name_length) is_port = 1'b1;
         end

         if (is_port) port_bytes = {port_bytes[7:0], value};
         if (seen_count < COUNT_MAX) seen_count = seen_count + 9'd1;

         if (last) begin
            if (atyp_kind == ADDR_IPV4) begin
               need = LEN_IPV4;
               alen = 8'd4;
            end else if (atyp_kind == ADDR_IPV6) begin
               need = LEN_IPV6;
               alen = 8'd16;
            end else if (atyp_kind == ADDR_DOMAIN) begin
               need = DOMAIN_OVERHEAD + name_length;
               alen = name_length;
            end
            ok = !header_bad && (atyp_kind != ADDR_NONE) && (seen_count == need);
            want.kind = ok ? KIND_ACCEPT : KIND_REJECT;
            if (ok) begin
               want.port_number = port_bytes;
               want.is_domain   = (atyp_kind == ADDR_DOMAIN);
               want.addr_length = alen;
            end
            awaited.push_back(want);
            clear();
         end else if (is_addr) begin
            want.kind       = KIND_ADDR;
            want.addr_byte  = value;
            want.addr_index = idx;
            awaited.push_back(want);
         end
      endfunction

      function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want_v,
                     got_v);
            failures++;
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            $display("%0t ns: unexpected response, expected none actual kind %0d", $time,
                     got.kind);
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", 16'(want.kind), 16'(got.kind));
         compare_field("addr_byte", 16'(want.addr_byte), 16'(got.addr_byte));
         compare_field("addr_index", 16'(want.addr_index), 16'(got.addr_index));
         compare_field("port_number", want.port_number, got.port_number);
         compare_field("is_domain", 16'(want.is_domain), 16'(got.is_domain));
         compare_field("addr_length", 16'(want.addr_length), 16'(got.addr_length));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_addr_byte;
   logic [7:0]  rsp_addr_index;
   logic [15:0] rsp_port_number;
   logic        rsp_is_domain;
   logic [7:0]  rsp_addr_length;

   parser_scoreboard board = new();

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   bit          hold_off_pending;
   int unsigned quiet_cycles;
   int unsigned sent_items;
   logic [7:0]  message[$];

   proxy_connect_request_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_addr_byte      (rsp_addr_byte),
      .rsp_addr_index     (rsp_addr_index),
      .rsp_port_number    (rsp_port_number),
      .rsp_is_domain      (rsp_is_domain),
      .rsp_addr_length    (rsp_addr_length)
   );

   always #4 clock = ~clock;

   // receiver: random stall, or a long hold-off while the queue fills
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left        = HoldOffCycles;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      bit         req_taken;
      bit         rsp_taken;
      result_type got;
      if (!reset) begin
         req_taken = (req_valid === 1'b1) && (req_stall === 1'b0);
         rsp_taken = (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
         if (req_taken) board.note_request(req_in_byte, req_end_of_message);
         if (rsp_taken) begin
            got.kind        = kind_type'(rsp_kind);
            got.addr_byte   = rsp_addr_byte;
            got.addr_index  = rsp_addr_index;
            got.port_number = rsp_port_number;
            got.is_domain   = rsp_is_domain;
            got.addr_length = rsp_addr_length;
            board.check_response(got);
         end
         if (req_taken || rsp_taken) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [7:0] value, input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_in_byte        <= value;
      req_end_of_message <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic send_message();
      foreach (message[i]) send_request(message[i], i == message.size() - 1);
   endtask

   task automatic put_header(input logic [7:0] atyp);
      message.push_back(8'(SOCKS_VERSION));
      message.push_back(8'(CMD_CONNECT));
      message.push_back(8'(RSV_VALUE));
      message.push_back(atyp);
   endtask

   task automatic put_random(input int unsigned count);
      repeat (count) message.push_back(8'($urandom_range(255)));
   endtask

   // mostly well-formed requests, some broken, some noise
   task automatic build_random_message();
      int unsigned shape;
      int unsigned name_len;
      int unsigned cut;
      message.delete();
      shape = $urandom_range(99);
      if (shape < 80) begin
         case ($urandom_range(2))
            0: begin
               put_header(8'(ATYP_IPV4));
               put_random(LEN_IPV4 - HEADER_LEN);
            end
            1: begin
               put_header(8'(ATYP_IPV6));
               put_random(LEN_IPV6 - HEADER_LEN);
            end
            default: begin
               name_len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
               put_header(8'(ATYP_DOMAIN));
               message.push_back(8'(name_len));
               put_random(name_len + PORT_LEN);
            end
         endcase
         if (shape >= 60) begin
            case ($urandom_range(3))
               0: message[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
               1: message[HEADER_LEN - 1] = 8'($urandom_range(255));
               2: begin
                  cut = $urandom_range(1, message.size() - 1);
                  while (message.size() > cut) void'(message.pop_back());
               end
               default: put_random($urandom_range(1, 6));
            endcase
         end
      end else begin
         put_random($urandom_range(1, 12));
      end
   endtask

   initial begin
      int unsigned send_pcts[4];
      int unsigned stall_pcts[4];
      send_pcts  = '{0, 53, 0, 31};
      stall_pcts = '{0, 0, 53, 31};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_in_byte        = '0;
      req_end_of_message = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      hold_off_pending   = 1'b0;
      quiet_cycles       = 0;
      sent_items         = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // single byte request, all ones
      message = {8'hff};
      send_message();
      // good ipv4
      message = {8'h05, 8'h01, 8'h00, 8'h01, 8'h00, 8'hff, 8'h80, 8'h7f, 8'hff, 8'h00};
      send_message();
      // empty domain name
      message = {8'h05, 8'h01, 8'h00, 8'h03, 8'h00, 8'h12, 8'h34};
      send_message();
      // unknown address type
      message = {8'h05, 8'h01, 8'h00, 8'h02};
      send_message();
      // bad version, ends on the first address byte, which yields only the verdict
      message = {8'h04, 8'h01, 8'h00, 8'h01, 8'haa};
      send_message();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pcts[phase];
         stall_pct     = stall_pcts[phase];
         sent_items    = 0;
         if (phase == 0) hold_off_pending = 1'b1;
         if (phase == 1) begin
            // overlong request saturates the byte count
            message.delete();
            put_header(8'(ATYP_IPV4));
            put_random($urandom_range(COUNT_MAX + 1, COUNT_MAX + 20) - HEADER_LEN);
            send_message();
            sent_items = 0;
         end
         while (sent_items < PhaseItems) begin
            build_random_message();
            send_message();
         end
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
